// ----- design/prt_pkg.sv -----
// ---------------------------------------------------------------------------
// Resequencer package
// Shared types and constants of the packet resequencer.
// ---------------------------------------------------------------------------
package prt_pkg;

  localparam int BufferDepth = 16;
  localparam int IdxW = $clog2(BufferDepth);
  localparam int CntW = $clog2(BufferDepth + 1);

  localparam logic [1:0] OUT_IN_ORDER = 2'd0;
  localparam logic [1:0] OUT_LATE_REL = 2'd1;
  localparam logic [1:0] OUT_LATE_DROP = 2'd2;
  localparam logic [1:0] OUT_OVERFLOW = 2'd3;

  localparam logic ACT_PACKET = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] seq_no;
    logic [47:0] sent_time;
    logic [47:0] now_time;
    logic [15:0] packet_tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [31:0] out_seq_no;
    logic [15:0] out_tag;
    logic        last;
  } out_item_t;

  // Classified work handed from the front part to the back part.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_EMIT,
    CMD_HOLD,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [1:0]  outcome;
    logic [31:0] seq_no;
    logic [47:0] sent_time;
    logic [47:0] now_time;
    logic [15:0] tag;
    logic [47:0] max_delay;
  } cmd_t;

endpackage

// ----- design/prt_front.sv -----
// ---------------------------------------------------------------------------
// Resequencer front part
// Accepts items, tracks the maximum delay and classifies each item.
// ---------------------------------------------------------------------------
module prt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  prt_pkg::in_item_t in_item,
  input  logic              drop_late,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output prt_pkg::cmd_t     cmd
);

  logic [47:0] max_delay;
  logic        neg;
  logic [47:0] delay;
  logic        late;

  assign in_ready = !cmd_valid || cmd_ready;

  assign neg   = in_item.sent_time > in_item.now_time;
  assign delay = in_item.now_time - in_item.sent_time;
  assign late  = !neg && (delay >= max_delay);

  // The front cannot see expected_seq, so the back decides in-order first;
  // late is pre-resolved here and overflow is pre-set as the hold outcome for the out-of-order case.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_delay <= '0;
      cmd_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        cmd_valid <= 1'b1;
      end else if (cmd_ready) begin
        cmd_valid <= 1'b0;
      end
      if (in_valid && in_ready) begin
        if (in_item.action == prt_pkg::ACT_PACKET && !neg && delay > max_delay) begin
          max_delay <= delay;
        end
        cmd.seq_no    <= in_item.seq_no;
        cmd.sent_time <= in_item.sent_time;
        cmd.now_time  <= in_item.now_time;
        cmd.tag       <= in_item.packet_tag;
        cmd.max_delay <= max_delay;
        if (in_item.action == prt_pkg::ACT_TICK) begin
          cmd.kind    <= prt_pkg::CMD_TICK;
          cmd.outcome <= prt_pkg::OUT_IN_ORDER;
        end else if (late) begin
          cmd.kind    <= prt_pkg::CMD_EMIT;
          cmd.outcome <= drop_late ? prt_pkg::OUT_LATE_DROP : prt_pkg::OUT_LATE_REL;
        end else begin
          cmd.kind    <= prt_pkg::CMD_HOLD;
          cmd.outcome <= prt_pkg::OUT_OVERFLOW;
        end
      end
    end
  end

endmodule

// ----- design/prt_back.sv -----
// ---------------------------------------------------------------------------
// Resequencer back part
// Holds the sorted buffer, releases in-order items, emits late and overflow results and handles timeouts.
// ---------------------------------------------------------------------------
module prt_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  prt_pkg::cmd_t      cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output prt_pkg::out_item_t out_item
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_SHIFT
  } state_t;

  state_t                    state;
  logic [31:0]               expected_seq;
  logic [prt_pkg::CntW-1:0]  count;
  logic [31:0]               hseq [prt_pkg::BufferDepth];
  logic [47:0]               htime [prt_pkg::BufferDepth];
  logic [15:0]               htag [prt_pkg::BufferDepth];
  logic [prt_pkg::IdxW-1:0]  ins_pos;
  logic [prt_pkg::BufferDepth-1:0] after;
  logic                      out_free;
  logic                      front_match;
  logic                      full;
  logic [48:0]               deadline;
  logic                      result_load;

  assign out_free    = !out_valid || out_ready;
  assign full        = count == prt_pkg::CntW'(prt_pkg::BufferDepth);
  assign front_match = count != '0 && hseq[0] == expected_seq;
  assign deadline    = {1'b0, htime[0]} + {1'b0, cmd.max_delay};
  assign cmd_ready   = state == ST_IDLE && out_free;

  // A new result is loaded into the output register this cycle.
  assign result_load = (state == ST_IDLE && cmd_valid && cmd_ready &&
                        ((cmd.kind != prt_pkg::CMD_TICK && cmd.seq_no == expected_seq) ||
                         cmd.kind == prt_pkg::CMD_EMIT ||
                         (cmd.kind == prt_pkg::CMD_HOLD && full))) ||
                       (state == ST_DRAIN && front_match && out_free);

  // Entries strictly later than the new item move up one place.
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < prt_pkg::BufferDepth; i++) begin
      after[i] = (prt_pkg::CntW'(i) < count) && (htime[i] > cmd.sent_time);
      if (prt_pkg::CntW'(i) < count && !after[i]) begin
        ins_pos = prt_pkg::IdxW'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      expected_seq <= '0;
      count        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            if (cmd.kind != prt_pkg::CMD_TICK && cmd.seq_no == expected_seq) begin
              out_item.outcome    <= prt_pkg::OUT_IN_ORDER;
              out_item.out_seq_no <= cmd.seq_no;
              out_item.out_tag    <= cmd.tag;
              out_item.last       <= !(count != '0 && hseq[0] == expected_seq + 32'd1);
              expected_seq        <= expected_seq + 32'd1;
              state               <= ST_DRAIN;
            end else if (cmd.kind == prt_pkg::CMD_EMIT ||
                         (cmd.kind == prt_pkg::CMD_HOLD && full)) begin
              out_item.outcome    <= cmd.outcome;
              out_item.out_seq_no <= cmd.seq_no;
              out_item.out_tag    <= cmd.tag;
              out_item.last       <= 1'b1;
            end else if (cmd.kind == prt_pkg::CMD_HOLD) begin
              for (int i = prt_pkg::BufferDepth - 1; i > 0; i--) begin
                if (after[i - 1]) begin
                  hseq[i]  <= hseq[i - 1];
                  htime[i] <= htime[i - 1];
                  htag[i]  <= htag[i - 1];
                end
              end
              hseq[ins_pos]  <= cmd.seq_no;
              htime[ins_pos] <= cmd.sent_time;
              htag[ins_pos]  <= cmd.tag;
              count          <= count + 1'b1;
            end else if (cmd.kind == prt_pkg::CMD_TICK && count != '0 &&
                         deadline <= {1'b0, cmd.now_time}) begin
              expected_seq <= hseq[0];
              state        <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (!front_match) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_item.outcome    <= prt_pkg::OUT_IN_ORDER;
            out_item.out_seq_no <= hseq[0];
            out_item.out_tag    <= htag[0];
            out_item.last       <= !(count > prt_pkg::CntW'(1) &&
                                     hseq[1] == expected_seq + 32'd1);
            expected_seq        <= expected_seq + 32'd1;
            state               <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          for (int i = 0; i < prt_pkg::BufferDepth - 1; i++) begin
            hseq[i]  <= hseq[i + 1];
            htime[i] <= htime[i + 1];
            htag[i]  <= htag[i + 1];
          end
          count <= count - 1'b1;
          state <= ST_DRAIN;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= prt_pkg::CntW'(prt_pkg::BufferDepth))
    else $error("buffer count out of range");
  a_shift_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_SHIFT |-> count != '0)
    else $error("shift with empty buffer");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !cmd_ready)
    else $error("command taken while draining");
`endif

endmodule

// ----- design/packet_resequencer_with_timeout.sv -----
// An accepted item is registered as a command in the front part; once the output is free,
// the back part registers its first result in the output register. Held or dropped items
// are taken back to back while the output is free; an in-order item or timeout starts a
// drain, during which no command is taken and each release is followed by a buffer shift.
// Reset (synchronous, rst high) empties the buffer, clears expected sequence,
// maximum delay and drop_late; no clearing pass is needed.
// ---------------------------------------------------------------------------
// Packet resequencer with timeout
// Front part classifies items, back part holds and releases them.
// ---------------------------------------------------------------------------
module packet_resequencer_with_timeout (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  prt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output prt_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  logic          drop_late;
  logic          cmd_valid;
  logic          cmd_ready;
  prt_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_late <= 1'b0;
    end else if (cfg_valid) begin
      drop_late <= cfg_data;
    end
  end

  prt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_data),
    .drop_late (drop_late),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  prt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_data)
  );

endmodule

// ----- dv/packet_resequencer_with_timeout_test.sv -----
// ---------------------------------------------------------------------------
// Packet resequencer testbench
// Drives arrivals and ticks through valid/ready channels with random idling,
// predicts every release and drop, and checks results in order.
// ---------------------------------------------------------------------------
module packet_resequencer_with_timeout_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 3000;
  localparam int DrainWait = 40;
  localparam int LongHold = 400;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  prt_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  prt_pkg::out_item_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_data;

  packet_resequencer_with_timeout u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // Mirror of the block's state.
  logic        drop_late_q;
  logic [31:0] next_seq;
  logic [47:0] worst_delay;
  logic [31:0] buf_seq[prt_pkg::BufferDepth];
  logic [47:0] buf_sent[prt_pkg::BufferDepth];
  logic [15:0] buf_tag[prt_pkg::BufferDepth];
  int          buf_count;

  prt_pkg::in_item_t  pending_items[$];
  prt_pkg::out_item_t expected_releases[$];
  bit        in_taken;
  bit        quiet;
  bit        long_hold_req;
  int        send_gap;
  int        recv_gap;
  int        hold_left;
  int        idle_cycles;
  int        errors;
  logic [31:0] gen_seq;
  logic [47:0] gen_time;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic prt_pkg::in_item_t mk(logic act, logic [31:0] seq, logic [47:0] sent,
                                           logic [47:0] now);
    prt_pkg::in_item_t it;
    it.action = act;
    it.seq_no = seq;
    it.sent_time = sent;
    it.now_time = now;
    it.packet_tag = 16'($urandom);
    return it;
  endfunction

  function automatic void add_result(logic [1:0] oc, logic [31:0] seq, logic [15:0] tag);
    prt_pkg::out_item_t r;
    r.outcome = oc;
    r.out_seq_no = seq;
    r.out_tag = tag;
    r.last = 1'b0;
    expected_releases.push_back(r);
  endfunction

  // Releases held packets while the front of the buffer is next in order.
  function automatic void release_in_order();
    while (buf_count > 0 && buf_seq[0] == next_seq) begin
      add_result(prt_pkg::OUT_IN_ORDER, buf_seq[0], buf_tag[0]);
      next_seq = next_seq + 32'd1;
      for (int i = 1; i < buf_count; i++) begin
        buf_seq[i-1] = buf_seq[i];
        buf_sent[i-1] = buf_sent[i];
        buf_tag[i-1] = buf_tag[i];
      end
      buf_count--;
    end
  endfunction

  function automatic void predict_item(prt_pkg::in_item_t it);
    int n_prior;
    int pos;
    bit neg;
    bit late;
    logic [47:0] delay;
    prt_pkg::out_item_t r;
    n_prior = expected_releases.size();
    if (it.action == prt_pkg::ACT_PACKET) begin
      neg = it.sent_time > it.now_time;
      delay = neg ? 48'd0 : it.now_time - it.sent_time;
      late = !neg && delay >= worst_delay;
      if (!neg && delay > worst_delay) worst_delay = delay;
      if (it.seq_no == next_seq) begin
        add_result(prt_pkg::OUT_IN_ORDER, it.seq_no, it.packet_tag);
        next_seq = next_seq + 32'd1;
        release_in_order();
      end else if (late) begin
        add_result(drop_late_q ? prt_pkg::OUT_LATE_DROP : prt_pkg::OUT_LATE_REL,
                   it.seq_no, it.packet_tag);
      end else if (buf_count >= prt_pkg::BufferDepth) begin
        add_result(prt_pkg::OUT_OVERFLOW, it.seq_no, it.packet_tag);
      end else begin
        // Equal sent times keep arrival order.
        pos = buf_count;
        while (pos > 0 && buf_sent[pos-1] > it.sent_time) pos--;
        for (int i = buf_count; i > pos; i--) begin
          buf_seq[i] = buf_seq[i-1];
          buf_sent[i] = buf_sent[i-1];
          buf_tag[i] = buf_tag[i-1];
        end
        buf_seq[pos] = it.seq_no;
        buf_sent[pos] = it.sent_time;
        buf_tag[pos] = it.packet_tag;
        buf_count++;
      end
    end else if (buf_count > 0 &&
                 {1'b0, buf_sent[0]} + {1'b0, worst_delay} <= {1'b0, it.now_time}) begin
      next_seq = buf_seq[0];
      release_in_order();
    end
    if (expected_releases.size() > n_prior) begin
      r = expected_releases.pop_back();
      r.last = 1'b1;
      expected_releases.push_back(r);
    end
  endfunction

  // Sender.
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver.
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req <= 1'b0;
      hold_left <= LongHold;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 7) == 0) recv_gap <= $urandom_range(1, 9);
    end
  end

  // Monitor, predictor hookup and watchdog.
  always @(posedge clk) begin
    prt_pkg::out_item_t want;
    in_taken = in_valid && in_ready && !rst;
    if (!rst && out_valid && out_ready) begin
      if (expected_releases.size() == 0) begin
        $error("unexpected item: seq %0h tag %0h", out_data.out_seq_no, out_data.out_tag);
        errors++;
      end else begin
        want = expected_releases.pop_front();
        if (out_data.outcome !== want.outcome) begin
          $error("outcome: expected %0d actual %0d", want.outcome, out_data.outcome);
          errors++;
        end
        if (out_data.out_seq_no !== want.out_seq_no) begin
          $error("out_seq_no: expected %0h actual %0h", want.out_seq_no, out_data.out_seq_no);
          errors++;
        end
        if (out_data.out_tag !== want.out_tag) begin
          $error("out_tag: expected %0h actual %0h", want.out_tag, out_data.out_tag);
          errors++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d actual %0d", want.last, out_data.last);
          errors++;
        end
      end
    end
    if (in_taken) predict_item(in_data);
    if (!rst && cfg_valid && cfg_ready) drop_late_q = cfg_data;
    if (rst || in_taken || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_releases.size() != 0)
      @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    gen_seq = next_seq;
  endtask

  task automatic write_drop_late(logic v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One run of consecutive packets, shuffled, sometimes with a gap that a
  // tick has to time out, a stale duplicate, or junk.
  task automatic push_window();
    prt_pkg::in_item_t win[$];
    prt_pkg::in_item_t t;
    int k;
    int skip;
    int j;
    logic [47:0] sent;
    k = $urandom_range(1, 8);
    skip = ($urandom_range(0, 4) == 0) ? $urandom_range(0, k - 1) : -1;
    for (int i = 0; i < k; i++) begin
      sent = gen_time + 48'(2 * i);
      if (i != skip) win.push_back(mk(prt_pkg::ACT_PACKET, gen_seq + 32'(i), sent,
                                      sent + 48'($urandom_range(0, 10))));
    end
    if ($urandom_range(0, 5) == 0)
      win.push_back(mk(prt_pkg::ACT_PACKET, gen_seq - 32'($urandom_range(1, 4)),
                       gen_time - 48'd40, gen_time));
    if ($urandom_range(0, 7) == 0)
      win.push_back(mk(prt_pkg::ACT_PACKET, $urandom,
                       gen_time + 48'($urandom_range(1, 3000)), gen_time));
    for (int i = win.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = win[i];
      win[i] = win[j];
      win[j] = t;
    end
    if ($urandom_range(0, 3) == 0)
      win.push_back(mk(prt_pkg::ACT_TICK, $urandom, 48'($urandom), gen_time));
    if (skip >= 0)
      win.push_back(mk(prt_pkg::ACT_TICK, $urandom, 48'($urandom),
                       gen_time + 48'(2 * k + 60)));
    foreach (win[i]) pending_items.push_back(win[i]);
    gen_seq = gen_seq + 32'(k);
    gen_time = gen_time + 48'(2 * k + 4);
  endtask

  initial begin
    int sent_count;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    drop_late_q = 1'b0;
    next_seq = '0;
    worst_delay = '0;
    buf_count = 0;
    errors = 0;
    idle_cycles = 0;
    send_gap = 0;
    recv_gap = 0;
    hold_left = 0;
    long_hold_req = 1'b0;
    quiet = 1'b0;
    in_taken = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_drop_late(1'b0);
    // Directed: in order, late release, sorted holds with equal sent times,
    // negative delay, unreached and reached timeouts, full buffer, wrap.
    pending_items.push_back(mk(prt_pkg::ACT_PACKET, 32'd0, 48'd0, 48'd0));
    pending_items.push_back(mk(prt_pkg::ACT_PACKET, 32'd2, 48'd10, 48'd15));
    pending_items.push_back(mk(prt_pkg::ACT_PACKET, 32'd3, 48'd20, 48'd22));
    pending_items.push_back(mk(prt_pkg::ACT_PACKET, 32'd2, 48'd18, 48'd20));
    pending_items.push_back(mk(prt_pkg::ACT_PACKET, 32'd4, 48'd20, 48'd21));
    pending_items.push_back(mk(prt_pkg::ACT_PACKET, 32'd1, 48'd30, 48'd31));
    pending_items.push_back(mk(prt_pkg::ACT_TICK, 32'd0, 48'd0, 48'd500));
    pending_items.push_back(mk(prt_pkg::ACT_PACKET, 32'd9, 48'd100, 48'd50));
    pending_items.push_back(mk(prt_pkg::ACT_TICK, 32'd0, 48'd0, 48'd0));
    pending_items.push_back(mk(prt_pkg::ACT_TICK, 32'd0, 48'd0, 48'd200));
    for (int i = 0; i < prt_pkg::BufferDepth; i++)
      pending_items.push_back(mk(prt_pkg::ACT_PACKET, 32'd100 + 32'(i), 48'd300, 48'd301));
    pending_items.push_back(mk(prt_pkg::ACT_PACKET, 32'd200, 48'd300, 48'd301));
    pending_items.push_back(mk(prt_pkg::ACT_TICK, 32'd0, 48'd0, 48'd1000));
    pending_items.push_back(mk(prt_pkg::ACT_PACKET, 32'hFFFF_FFFF, 48'd2000, 48'd2001));
    pending_items.push_back(mk(prt_pkg::ACT_TICK, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                               48'd3000));
    pending_items.push_back(mk(prt_pkg::ACT_PACKET, 32'd0, 48'd3000, 48'd3001));
    sent_count = pending_items.size();
    wait_idle();
    gen_time = 48'd4000;

    for (int phase = 0; phase < 4; phase++) begin
      write_drop_late(phase[0]);
      if (phase == 1) begin
        long_hold_req = 1'b1;
        sent_count -= pending_items.size();
        repeat (8) push_window();
        sent_count += pending_items.size();
      end
      if (phase == 3) quiet = 1'b1;
      while (sent_count < 60 * (phase + 1)) begin
        sent_count -= pending_items.size();
        push_window();
        sent_count += pending_items.size();
        if ($urandom_range(0, 3) == 0) wait_idle();
      end
      // The test holds off here until every expected item is back.
      wait_idle();
    end

    // Field extremes last, since a huge delay keeps the maximum high.
    pending_items.push_back(mk(prt_pkg::ACT_PACKET, 32'h5555_5555, 48'hFFFF_FFFF_FFFF,
                               48'd0));
    pending_items.push_back(mk(prt_pkg::ACT_PACKET, 32'hAAAA_AAAA, 48'd0,
                               48'hFFFF_FFFF_FFFF));
    pending_items.push_back(mk(prt_pkg::ACT_PACKET, 32'h1234_5678, 48'd7, 48'd9));
    pending_items.push_back(mk(prt_pkg::ACT_TICK, 32'h0, 48'h0, 48'hFFFF_FFFF_FFFF));
    pending_items.push_back(mk(prt_pkg::ACT_TICK, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                               48'hFFFF_FFFF_FFFF));
    wait_idle();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
